>>> hdl/xps_pkg.sv
`default_nettype none

package xps_pkg;

	localparam int PACKET_BYTES_DEF = 128;

	// line characters
	localparam logic [7:0] CH_SOH = 8'h01;
	localparam logic [7:0] CH_EOT = 8'h04;
	localparam logic [7:0] CH_ACK = 8'h06;
	localparam logic [7:0] CH_NAK = 8'h15;
	localparam logic [7:0] CH_C   = 8'h43;

	// operation codes on the input channel
	localparam logic [2:0] OP_LINE  = 3'd0;
	localparam logic [2:0] OP_DATA  = 3'd1;
	localparam logic [2:0] OP_EOF   = 3'd2;
	localparam logic [2:0] OP_READY = 3'd3;
	localparam logic [2:0] OP_ABORT = 3'd4;

	localparam logic [3:0]  RETRY_LIMIT_RST = 4'd2;
	localparam logic [16:0] CRC_POLY        = 17'h11021;

	typedef enum logic [2:0] {
		PH_MODE,
		PH_FILL,
		PH_SEND,
		PH_REPLY,
		PH_EOT,
		PH_DONE,
		PH_ABORT
	} phase_t;

	// crc-16, msb first, one byte
	function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
		logic [16:0] a;
		a = {1'b0, acc ^ {b, 8'h00}};
		for (int k = 0; k < 8; k++) begin
			a = {a[15:0], 1'b0};
			if (a[16]) begin
				a = a ^ CRC_POLY;
			end
		end
		return a[15:0];
	endfunction

endpackage

`default_nettype wire

>>> hdl/xps_ram.sv
`default_nettype none

module xps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

>>> hdl/xmodem_packet_sender.sv
// xmodem packet sender
// input channel s_*: one operation per transfer, op in s_tuser, byte in s_tdata
// (line byte from the receiver, file byte, end of file, transmitter ready, abort).
// output channel m_*: exactly one result per input transfer, held in an output
// register; a result appears in the cycle after its input transfer is taken.
// throughput is one transfer per cycle while the receiver does not stall: all state
// updates in a single pass of logic, including the bytewise crc-16 xor network.
// file bytes go into a packet ram; its registered read port is addressed from the
// next send position so the byte for the following ready transfer is already out.
// cfg_* writes mode_retry_limit; take it only while the block is idle.
// when the receiver stalls (m_tready low with a result pending) s_tready drops
// and nothing is lost; a pending result is replaced in the same cycle it is taken.
// reset: waits for the mode byte, block number 1, retry limit 2; the packet ram
// needs no clearing since positions beyond the fill count are sent as 00.
`default_nettype none

module xmodem_packet_sender #(
	parameter int PACKET_BYTES = xps_pkg::PACKET_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [3:0]  cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // byte_value[7:0]
	input  wire logic [2:0]  s_tuser,  // op[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata,  // tx_byte[7:0], need_data, crc_mode, finished, aborted
	output logic      [0:0]  m_tuser   // tx_valid
);

	localparam int AW = $clog2(PACKET_BYTES);
	localparam int FW = $clog2(PACKET_BYTES + 1);
	localparam int SW = $clog2(PACKET_BYTES + 6);

	localparam logic [FW-1:0] FILL_FULL  = FW'(PACKET_BYTES);
	localparam logic [SW-1:0] IDX_SOH    = SW'(0);
	localparam logic [SW-1:0] IDX_BLK    = SW'(1);
	localparam logic [SW-1:0] IDX_NBLK   = SW'(2);
	localparam logic [SW-1:0] IDX_DATA   = SW'(3);
	localparam logic [SW-1:0] IDX_CHK_HI = SW'(PACKET_BYTES + 3);

	xps_pkg::phase_t phase_q, phase_d;
	logic [FW-1:0] fill_q, fill_d;
	logic [SW-1:0] send_idx_q, send_idx_d;
	logic [7:0]    block_q, block_d;
	logic [15:0]   acc_q, acc_d;
	logic          crc_q, crc_d;
	logic          end_q, end_d;
	logic [3:0]    retry_q, retry_d;
	logic [3:0]    limit_q;

	logic          m_tvalid_q;
	logic [15:0]   m_tdata_q;
	logic          m_tuser_q;

	logic          accept;
	logic [2:0]    op;
	logic [7:0]    bv;
	logic          live;
	logic [FW-1:0] fill_inc;
	logic [3:0]    retry_inc;

	logic          ram_we;
	logic [SW-1:0] rd_idx;
	logic [7:0]    ram_rdata;

	logic [SW-1:0] d_idx;
	logic [7:0]    data_byte;
	logic [7:0]    pkt_byte;
	logic          tx_valid;
	logic [7:0]    tx_byte;

	assign accept    = s_tvalid && s_tready;
	assign op        = s_tuser;
	assign bv        = s_tdata;
	assign s_tready  = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;
	assign live      = (phase_q != xps_pkg::PH_DONE) && (phase_q != xps_pkg::PH_ABORT);
	assign fill_inc  = fill_q + FW'(1);
	assign retry_inc = retry_q + 4'd1;

	// packet store, read address follows the next send position
	assign ram_we = accept && live && (op == xps_pkg::OP_DATA) &&
		(phase_q == xps_pkg::PH_FILL) && (fill_q < FILL_FULL);
	assign rd_idx = send_idx_d - IDX_DATA;

	xps_ram #(
		.WIDTH(8),
		.DEPTH(PACKET_BYTES)
	) u_store (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(fill_q[AW-1:0]),
		.wr_data(bv),
		.rd_addr(rd_idx[AW-1:0]),
		.rd_data(ram_rdata)
	);

	// output logic: byte at the current send position
	always_comb begin
		d_idx     = send_idx_q - IDX_DATA;
		data_byte = (d_idx < SW'(fill_q)) ? ram_rdata : 8'h00;
		if (send_idx_q == IDX_SOH) begin
			pkt_byte = xps_pkg::CH_SOH;
		end else if (send_idx_q == IDX_BLK) begin
			pkt_byte = block_q;
		end else if (send_idx_q == IDX_NBLK) begin
			pkt_byte = ~block_q;
		end else if (send_idx_q < IDX_CHK_HI) begin
			pkt_byte = data_byte;
		end else if (send_idx_q == IDX_CHK_HI && crc_q) begin
			pkt_byte = acc_q[15:8];
		end else begin
			pkt_byte = acc_q[7:0];
		end
		tx_valid = 1'b0;
		tx_byte  = 8'h00;
		if (live && op == xps_pkg::OP_READY) begin
			unique case (phase_q)
				xps_pkg::PH_SEND: begin
					tx_valid = 1'b1;
					tx_byte  = pkt_byte;
				end
				xps_pkg::PH_EOT: begin
					tx_valid = 1'b1;
					tx_byte  = xps_pkg::CH_EOT;
				end
				default: begin
					tx_valid = 1'b0;
				end
			endcase
		end
	end

	// next state
	always_comb begin
		phase_d    = phase_q;
		fill_d     = fill_q;
		send_idx_d = send_idx_q;
		block_d    = block_q;
		acc_d      = acc_q;
		crc_d      = crc_q;
		end_d      = end_q;
		retry_d    = retry_q;
		if (accept && live) begin
			case (op)
				xps_pkg::OP_ABORT: begin
					phase_d = xps_pkg::PH_ABORT;
				end
				xps_pkg::OP_EOF: begin
					end_d = 1'b1;
					if (phase_q == xps_pkg::PH_FILL) begin
						if (fill_q == '0) begin
							phase_d = xps_pkg::PH_EOT;
						end else begin
							send_idx_d = '0;
							phase_d    = xps_pkg::PH_SEND;
						end
					end
				end
				xps_pkg::OP_LINE: begin
					if (phase_q == xps_pkg::PH_MODE) begin
						if (bv == xps_pkg::CH_NAK || bv == xps_pkg::CH_C) begin
							crc_d   = (bv == xps_pkg::CH_C);
							fill_d  = '0;
							phase_d = end_q ? xps_pkg::PH_EOT : xps_pkg::PH_FILL;
						end else begin
							retry_d = retry_inc;
							if (retry_inc >= limit_q) begin
								phase_d = xps_pkg::PH_ABORT;
							end
						end
					end else if (phase_q == xps_pkg::PH_REPLY) begin
						if (bv == xps_pkg::CH_ACK) begin
							block_d = block_q + 8'd1;
							fill_d  = '0;
							phase_d = end_q ? xps_pkg::PH_EOT : xps_pkg::PH_FILL;
						end else begin
							send_idx_d = '0;
							phase_d    = xps_pkg::PH_SEND;
						end
					end
				end
				xps_pkg::OP_DATA: begin
					if (ram_we) begin
						fill_d = fill_inc;
						if (fill_inc == FILL_FULL) begin
							send_idx_d = '0;
							phase_d    = xps_pkg::PH_SEND;
						end
					end
				end
				xps_pkg::OP_READY: begin
					if (phase_q == xps_pkg::PH_SEND) begin
						send_idx_d = send_idx_q + SW'(1);
						if (send_idx_q == IDX_SOH) begin
							acc_d = '0;
						end else if (send_idx_q >= IDX_DATA && send_idx_q < IDX_CHK_HI) begin
							acc_d = crc_q ? xps_pkg::crc16_byte(acc_q, data_byte)
								: acc_q + {8'h00, data_byte};
						end else if (send_idx_q == IDX_CHK_HI) begin
							if (!crc_q) begin
								phase_d = xps_pkg::PH_REPLY;
							end
						end else if (send_idx_q > IDX_CHK_HI) begin
							phase_d = xps_pkg::PH_REPLY;
						end
					end else if (phase_q == xps_pkg::PH_EOT) begin
						phase_d = xps_pkg::PH_DONE;
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= xps_pkg::PH_MODE;
			fill_q     <= '0;
			send_idx_q <= '0;
			block_q    <= 8'd1;
			acc_q      <= '0;
			crc_q      <= 1'b0;
			end_q      <= 1'b0;
			retry_q    <= '0;
			limit_q    <= xps_pkg::RETRY_LIMIT_RST;
			m_tvalid_q <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			fill_q     <= fill_d;
			send_idx_q <= send_idx_d;
			block_q    <= block_d;
			acc_q      <= acc_d;
			crc_q      <= crc_d;
			end_q      <= end_d;
			retry_q    <= retry_d;
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// result register, payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= {4'h0,
				phase_d == xps_pkg::PH_ABORT,
				phase_d == xps_pkg::PH_DONE,
				crc_d,
				phase_d == xps_pkg::PH_FILL,
				tx_byte};
			m_tuser_q <= tx_valid;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

`ifndef SYNTH
	// a byte goes out only while the store is not being filled
	a_tx_not_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tdata[8])
		else $error("transmit result shows need_data");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_FULL)
		else $error("fill count beyond packet size");

	a_send_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == xps_pkg::PH_SEND |-> send_idx_q <= IDX_CHK_HI + SW'(1))
		else $error("send position beyond packet end");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == xps_pkg::PH_DONE |=> phase_q == xps_pkg::PH_DONE)
		else $error("left finished phase");
`endif

endmodule

`default_nettype wire
